/* sv/blrp_pkg.sv */
// Shared types and constants of the bottom-left rectangle placer.
// No dependencies; the cells, the root/divide unit, the placer and the testbench import it.
package blrp_pkg;

	localparam int MAX_OBST = 64;
	localparam int IDX_W = $clog2(MAX_OBST);
	localparam int CNT_W = $clog2(MAX_OBST + 1);
	localparam int POS_W = CNT_W + 1;
	localparam int SHAPES = 6;
	localparam logic [15:0] CHIP_RESET = 16'd1024;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_PLACE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_PLACED  = 3'd1,
		ST_NOFIT   = 3'd2,
		ST_FULL    = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_t;

	typedef enum logic [1:0] {
		RT_A    = 2'd0,
		RT_2A   = 2'd1,
		RT_HALF = 2'd2
	} root_t;

	typedef enum logic [1:0] {
		SD_IDLE,
		SD_ROOT,
		SD_DIV,
		SD_DONE
	} sd_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_ROOT_GO,
		C_ROOT_WAIT,
		C_PUSH1,
		C_PUSH2,
		C_SHAPE,
		C_POS,
		C_FETCH_WAIT,
		C_CHECK,
		C_DROP,
		C_DROP_WAIT,
		C_FINISH,
		C_RESP
	} ctl_state_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
	} rect_t;

	// probe that walks the cell chain
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] sel;
		logic [15:0]      x;
		logic [15:0]      y;
		logic [15:0]      w;
		logic [15:0]      h;
		logic             hit;
		logic [16:0]      top;
		logic [15:0]      fx;
		logic [15:0]      fw;
	} probe_t;

endpackage

/* sv/blrp_ifs.sv */
// Channel interfaces of the placer: request, response and config write.
// Standalone; widths fixed by the field list.
interface blrp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] rect_x;
	logic [15:0] rect_y;
	logic [15:0] rect_w;
	logic [15:0] rect_h;
	logic [31:0] area;
	modport source(output valid, operation, rect_x, rect_y, rect_w, rect_h, area, input ready);
	modport sink(input valid, operation, rect_x, rect_y, rect_w, rect_h, area, output ready);
endinterface

interface blrp_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] placed_x;
	logic [15:0] placed_y;
	logic [15:0] placed_w;
	logic [15:0] placed_h;
	logic [2:0]  status;
	modport source(output valid, placed_x, placed_y, placed_w, placed_h, status, input ready);
	modport sink(input valid, placed_x, placed_y, placed_w, placed_h, status, output ready);
endinterface

interface blrp_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/bottom_left_rect_placer.sv */
// Bottom-left rectangle placer: a table of up to MAX_OBST obstacles held in a
// chain of cells, one obstacle per cell. Every operation gives one response
// beat, except operation 3, which is swallowed. Clear and add-fixed go from
// idle straight to the response state. Place-soft first builds up to six
// shapes; each of the three roots comes from a binary-search square root
// followed by a bit-serial ceiling divide. Then every shape that fits the chip
// is tried at 2 + 2*count x positions; a position taken from an obstacle first
// costs one pass through the cell chain to fetch that obstacle, and each drop
// step is another full pass, with at most count + 1 drop steps per position.
// Placement time is therefore set by the chain length and the number of drop
// steps, and is shorter for area zero or for shapes that miss the chip. A new
// request is taken once the previous answer has moved into the response
// register; config writes are always accepted and must only arrive while the
// block is idle.
module bottom_left_rect_placer import blrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	blrp_req_if.sink   req,
	blrp_rsp_if.source rsp,
	blrp_cfg_if.sink   cfg
);

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      cw_q, ch_q;
	logic [31:0]      a_q;
	root_t            mode_q;
	logic [16:0]      sw_q [SHAPES];
	logic [16:0]      sh_q [SHAPES];
	logic [2:0]       n_q, s_q;
	logic [15:0]      pw_q, ph_q;
	logic [POS_W-1:0] i_q, i_lim;
	logic signed [17:0] xc_q;
	logic [16:0]      y_q;
	logic [CNT_W-1:0] it_q;
	logic             found_q;
	rect_t            best_q;
	rect_t            res_q;
	status_t          res_st_q;

	// handshake and control
	logic             accept;
	logic             full;
	logic             sq_start, sq_done;
	logic [16:0]      sq_r, sq_h;
	logic             wr_en;
	rect_t            wr_rect;
	probe_t           inj;
	probe_t           link [MAX_OBST+1];
	probe_t           tail;
	logic             out_free;

	// shape push checks
	logic [16:0]      pu_w, pu_h;
	logic             pu_ok, pu_dup;

	// position and drop helpers
	logic [17:0]      xr;
	logic [17:0]      yh;
	logic             shape_big;
	logic             better;

	assign accept = req.valid && req.ready;
	assign full = (count_q >= CNT_W'(MAX_OBST));
	assign out_free = !rsp.valid || rsp.ready;
	assign tail = link[MAX_OBST];
	assign i_lim = POS_W'(2) + {count_q, 1'b0};
	assign cfg.ready = 1'b1;

	blrp_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.a      (a_q),
		.mode   (mode_q),
		.done   (sq_done),
		.root   (sq_r),
		.quot   (sq_h)
	);

	// obstacle chain: a probe enters cell 0 and passes one register per cell to the tail
	assign link[0] = inj;
	for (genvar k = 0; k < MAX_OBST; k++) begin : g_cell
		blrp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(k)),
			.count   (count_q),
			.wr_en   (wr_en && (count_q == CNT_W'(k))),
			.wr_rect (wr_rect),
			.pin     (link[k]),
			.pout    (link[k+1])
		);
	end

	// shape push: first beat (r,h), second (h,r)
	always_comb begin
		pu_w = (state_q == C_PUSH1) ? sq_r : sq_h;
		pu_h = (state_q == C_PUSH1) ? sq_h : sq_r;
		pu_dup = 1'b0;
		for (int k = 0; k < SHAPES; k++) begin
			if ((3'(k) < n_q) && (sw_q[k] == pu_w) && (sh_q[k] == pu_h)) begin
				pu_dup = 1'b1;
			end
		end
		// area >= A holds by construction of h = ceil(A/r)
		pu_ok = (pu_w != 17'd0) && (pu_h != 17'd0) &&
			({pu_h, 1'b0} >= {1'b0, pu_w}) && ({1'b0, pu_h} <= {pu_w, 1'b0}) && !pu_dup;
	end

	assign shape_big = (sw_q[s_q] > {1'b0, cw_q}) || (sh_q[s_q] > {1'b0, ch_q});
	assign xr = 18'(xc_q[16:0]) + 18'(pw_q);
	assign yh = 18'(y_q) + 18'(ph_q);
	// strict compare keeps the earlier candidate on a tie
	assign better = !found_q || (y_q[15:0] < best_q.y) ||
		((y_q[15:0] == best_q.y) && (xc_q[15:0] < best_q.x));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (accept) begin
					unique case (op_t'(req.operation))
						OP_NONE:  state_d = C_IDLE;
						OP_CLEAR: state_d = C_RESP;
						OP_ADD:   state_d = C_RESP;
						OP_PLACE: begin
							if (full)                  state_d = C_RESP;
							else if (req.area == 32'd0) state_d = C_SHAPE;
							else                       state_d = C_ROOT_GO;
						end
						default:  state_d = C_IDLE;
					endcase
				end
			end
			C_ROOT_GO:   state_d = C_ROOT_WAIT;
			C_ROOT_WAIT: if (sq_done) state_d = C_PUSH1;
			C_PUSH1:     state_d = C_PUSH2;
			C_PUSH2:     state_d = (mode_q == RT_HALF) ? C_SHAPE : C_ROOT_GO;
			C_SHAPE: begin
				if (s_q == n_q)      state_d = C_FINISH;
				else if (!shape_big) state_d = C_POS;
			end
			C_POS: begin
				if (i_q == i_lim)                state_d = C_SHAPE;
				else if (i_q < POS_W'(2))        state_d = C_CHECK;
				else                             state_d = C_FETCH_WAIT;
			end
			C_FETCH_WAIT: if (tail.vld) state_d = C_CHECK;
			C_CHECK: begin
				if (xc_q[17] || (xr > 18'(cw_q))) state_d = C_POS;
				else                              state_d = C_DROP;
			end
			C_DROP: begin
				if ((it_q > count_q) || (yh > 18'(ch_q))) state_d = C_POS;
				else                                      state_d = C_DROP_WAIT;
			end
			C_DROP_WAIT: begin
				if (tail.vld) begin
					if (!tail.hit || (tail.top <= y_q)) state_d = C_POS;
					else                                state_d = C_DROP;
				end
			end
			C_FINISH:    state_d = C_RESP;
			C_RESP:      if (out_free) state_d = C_IDLE;
			default:     state_d = C_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = (state_q == C_IDLE);
		sq_start = (state_q == C_ROOT_GO);
		wr_en = 1'b0;
		wr_rect = best_q;
		if (accept && (op_t'(req.operation) == OP_ADD) && !full) begin
			wr_en = 1'b1;
			wr_rect = '{x: req.rect_x, y: req.rect_y, w: req.rect_w, h: req.rect_h};
		end else if ((state_q == C_FINISH) && found_q) begin
			wr_en = 1'b1;
		end
		inj = '0;
		inj.sel = IDX_W'((i_q - POS_W'(2)) >> 1);
		inj.x = xc_q[15:0];
		inj.y = y_q[15:0];
		inj.w = pw_q;
		inj.h = ph_q;
		if ((state_q == C_POS) && (i_q != i_lim) && (i_q >= POS_W'(2))) begin
			inj.vld = 1'b1;
		end
		if ((state_q == C_DROP) && (it_q <= count_q) && (yh <= 18'(ch_q))) begin
			inj.vld = 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			count_q <= '0;
			cw_q <= CHIP_RESET;
			ch_q <= CHIP_RESET;
			rsp.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (reg_t'(cfg.index))
					REG_WIDTH:  cw_q <= cfg.data;
					REG_HEIGHT: ch_q <= cfg.data;
					default:    ;
				endcase
			end
			if (accept && (op_t'(req.operation) == OP_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if ((state_q == C_RESP) && out_free) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				found_q <= 1'b0;
				s_q <= 3'd0;
				a_q <= req.area;
				mode_q <= RT_A;
				res_q <= '0;
				if (req.operation == OP_CLEAR) begin
					res_st_q <= ST_CLEARED;
				end else if (full) begin
					res_st_q <= ST_FULL;
				end else begin
					res_st_q <= ST_ADDED;
					res_q <= '{x: req.rect_x, y: req.rect_y, w: req.rect_w, h: req.rect_h};
				end
				if (req.area == 32'd0) begin
					sw_q[0] <= 17'd1;
					sh_q[0] <= 17'd1;
					n_q <= 3'd1;
				end else begin
					n_q <= 3'd0;
				end
			end
			C_PUSH1, C_PUSH2: begin
				if (pu_ok) begin
					sw_q[n_q] <= pu_w;
					sh_q[n_q] <= pu_h;
					n_q <= n_q + 3'd1;
				end
				if ((state_q == C_PUSH2) && (mode_q != RT_HALF)) begin
					mode_q <= root_t'(mode_q + 2'd1);
				end
			end
			C_SHAPE: begin
				pw_q <= sw_q[s_q][15:0];
				ph_q <= sh_q[s_q][15:0];
				i_q <= '0;
				if ((s_q != n_q) && shape_big) begin
					s_q <= s_q + 3'd1;
				end
			end
			C_POS: begin
				if (i_q == i_lim) begin
					s_q <= s_q + 3'd1;
				end else if (i_q == POS_W'(0)) begin
					xc_q <= '0;
				end else if (i_q == POS_W'(1)) begin
					xc_q <= (cw_q > pw_q) ? $signed(18'(cw_q - pw_q)) : '0;
				end
			end
			C_FETCH_WAIT: begin
				// even slot: right edge; odd slot: left edge minus width
				if (!i_q[0]) begin
					xc_q <= $signed(18'(tail.fx) + 18'(tail.fw));
				end else begin
					xc_q <= $signed(18'(tail.fx)) - $signed(18'(pw_q));
				end
			end
			C_CHECK: begin
				y_q <= '0;
				it_q <= '0;
				if (xc_q[17] || (xr > 18'(cw_q))) begin
					i_q <= i_q + POS_W'(1);
				end
			end
			C_DROP: begin
				if ((it_q > count_q) || (yh > 18'(ch_q))) begin
					i_q <= i_q + POS_W'(1);
				end
			end
			C_DROP_WAIT: begin
				if (tail.vld) begin
					if (!tail.hit) begin
						if (better) begin
							found_q <= 1'b1;
							best_q <= '{x: xc_q[15:0], y: y_q[15:0], w: pw_q, h: ph_q};
						end
						i_q <= i_q + POS_W'(1);
					end else if (tail.top <= y_q) begin
						i_q <= i_q + POS_W'(1);
					end else begin
						y_q <= tail.top;
						it_q <= it_q + CNT_W'(1);
					end
				end
			end
			C_FINISH: begin
				if (found_q) begin
					res_q <= best_q;
					res_st_q <= ST_PLACED;
				end else begin
					res_q <= '0;
					res_st_q <= ST_NOFIT;
				end
			end
			C_RESP: begin
				if (out_free) begin
					rsp.placed_x <= res_q.x;
					rsp.placed_y <= res_q.y;
					rsp.placed_w <= res_q.w;
					rsp.placed_h <= res_q.h;
					rsp.status <= res_st_q;
				end
			end
			default: ;
		endcase
	end

endmodule

/* sv/blrp_cell.sv */
// One obstacle cell of the chain: holds a rectangle, tests the passing probe.
// Depends on blrp_pkg.
module blrp_cell import blrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic [CNT_W-1:0] count,
	input  logic             wr_en,
	input  rect_t            wr_rect,
	input  probe_t           pin,
	output probe_t           pout
);

	rect_t       ent_q;
	probe_t      nxt;
	logic        active;
	logic        ovl;
	logic [16:0] oxr, oyr, pxr, pyr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q <= wr_rect;
		end
	end

	assign active = {1'b0, idx} < count;
	assign oxr = 17'(ent_q.x) + 17'(ent_q.w);
	assign oyr = 17'(ent_q.y) + 17'(ent_q.h);
	assign pxr = 17'(pin.x) + 17'(pin.w);
	assign pyr = 17'(pin.y) + 17'(pin.h);
	// positive-area intersection; zero-size boxes never overlap
	assign ovl = (17'(pin.x) < oxr) && (17'(ent_q.x) < pxr) &&
		(17'(pin.y) < oyr) && (17'(ent_q.y) < pyr) &&
		(ent_q.w != 16'd0) && (ent_q.h != 16'd0) &&
		(pin.w != 16'd0) && (pin.h != 16'd0);

	always_comb begin
		nxt = pin;
		if (active && ovl) begin
			nxt.hit = 1'b1;
			if (oyr > nxt.top) begin
				nxt.top = oyr;
			end
		end
		if (active && (idx == pin.sel)) begin
			nxt.fx = ent_q.x;
			nxt.fw = ent_q.w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pout <= '0;
		end else begin
			pout <= nxt;
		end
	end

endmodule

/* sv/blrp_sqdiv.sv */
// Iterative ceiling square root (binary search) followed by ceiling divide.
// Depends on blrp_pkg.
module blrp_sqdiv import blrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  root_t       mode,
	output logic        done,
	output logic [16:0] root,
	output logic [16:0] quot
);

	sd_state_t   sd_q, sd_d;
	logic [17:0] lo_q, hi_q, mid;
	logic [17:0] rem_q, remsh;
	logic [32:0] dvd_q;
	logic [5:0]  cnt_q;
	logic [35:0] sq;
	logic [36:0] lhs, num;
	logic        ge, sub_ok;

	assign mid = 18'((19'(lo_q) + 19'(hi_q)) >> 1);
	assign sq = mid * mid;
	assign lhs = (mode == RT_HALF) ? {sq, 1'b0} : {1'b0, sq};
	assign num = (mode == RT_2A) ? {4'd0, a, 1'b0} : {5'd0, a};
	assign ge = lhs >= num;
	assign remsh = {rem_q[16:0], dvd_q[32]};
	assign sub_ok = remsh >= lo_q;

	always_comb begin
		sd_d = sd_q;
		unique case (sd_q)
			SD_IDLE: if (start) sd_d = SD_ROOT;
			SD_ROOT: if (lo_q >= hi_q) sd_d = SD_DIV;
			SD_DIV:  if (cnt_q == 6'd1) sd_d = SD_DONE;
			SD_DONE: sd_d = SD_IDLE;
			default: sd_d = SD_IDLE;
		endcase
	end

	always_comb begin
		done = (sd_q == SD_DONE);
		root = lo_q[16:0];
		quot = dvd_q[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_q <= SD_IDLE;
		end else begin
			sd_q <= sd_d;
		end
	end

	// root and quotient hold after done until the next start
	always_ff @(posedge clk) begin
		case (sd_q)
			SD_IDLE: begin
				if (start) begin
					lo_q <= 18'd0;
					hi_q <= 18'd1 << 17;
				end
			end
			SD_ROOT: begin
				if (lo_q < hi_q) begin
					if (ge) hi_q <= mid;
					else    lo_q <= mid + 18'd1;
				end else begin
					// ceil(a / r) as floor((a + r - 1) / r)
					rem_q <= 18'd0;
					dvd_q <= 33'(a) + 33'(lo_q) - 33'd1;
					cnt_q <= 6'd33;
				end
			end
			SD_DIV: begin
				rem_q <= sub_ok ? (remsh - lo_q) : remsh;
				dvd_q <= {dvd_q[31:0], sub_ok};
				cnt_q <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

endmodule

/* tb/tb_bottom_left_rect_placer.sv */
// Self-checking testbench of the bottom-left rectangle placer.
// Depends on blrp_pkg, the channel interfaces and bottom_left_rect_placer.
module tb_bottom_left_rect_placer;
	import blrp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		rect_t   r;
		status_t st;
	} answer_t;

	typedef struct {
		logic [1:0]  op;
		rect_t       r;
		logic [31:0] a;
		bit          typed;   // expected answer written in the row
		answer_t     ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	blrp_req_if req();
	blrp_rsp_if rsp();
	blrp_cfg_if cfg();

	bottom_left_rect_placer uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	always #4 clk = ~clk;

	// mirror of the block state
	rect_t       obst[MAX_OBST];
	int unsigned obst_cnt;
	longint      chip_w = CHIP_RESET;
	longint      chip_h = CHIP_RESET;

	// shape list of the current placement
	longint shape_w[SHAPES];
	longint shape_h[SHAPES];
	int     shape_n;

	answer_t answer_q[$];
	int      errors;
	int      cycles;
	int      beats_seen;
	int      n_added, n_placed, n_nofit, n_full, n_cleared;
	bit      calm_src, calm_snk;
	int      hold_cnt;
	bit      hold_done;
	row_t    rows[$];

	// smallest r with r*r*den >= num
	function automatic longint least_root(longint num, longint den);
		longint lo, hi, mid;
		lo = 0;
		hi = longint'(1) << 17;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (mid * mid * den >= num)
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo;
	endfunction

	function automatic void shape_add(longint w, longint h, longint a);
		if (w <= 0 || h <= 0) return;
		if (w * h < a) return;
		if (!(2 * h >= w && h <= 2 * w)) return;
		for (int i = 0; i < shape_n; i++)
			if (shape_w[i] == w && shape_h[i] == h) return;
		shape_w[shape_n] = w;
		shape_h[shape_n] = h;
		shape_n++;
	endfunction

	// true when the box overlaps a stored obstacle; top = highest top edge hit
	function automatic bit overlaps(longint x, longint y, longint w, longint h,
			output longint top);
		longint ox, oy, ow, oh, lx, rx, ly, ry;
		bit any;
		any = 0;
		top = -1;
		for (int i = 0; i < obst_cnt; i++) begin
			ox = obst[i].x; oy = obst[i].y; ow = obst[i].w; oh = obst[i].h;
			lx = x > ox ? x : ox;
			rx = (x + w) < (ox + ow) ? (x + w) : (ox + ow);
			ly = y > oy ? y : oy;
			ry = (y + h) < (oy + oh) ? (y + h) : (oy + oh);
			if (rx - lx > 0 && ry - ly > 0) begin
				any = 1;
				if (oy + oh > top) top = oy + oh;
			end
		end
		return any;
	endfunction

	function automatic longint drop_y(longint x, longint w, longint h);
		longint y, top;
		y = 0;
		for (int it = 0; it <= obst_cnt; it++) begin
			if (y + h > chip_h) return -1;
			if (!overlaps(x, y, w, h, top)) return y;
			if (top <= y) return -1;
			y = top;
		end
		return -1;
	endfunction

	// applies one request to the mirror; returns 1 when it gives a response
	function automatic bit placer_answer(logic [1:0] op, rect_t r, logic [31:0] area,
			output answer_t ans);
		longint a, rt, h, w, x, y, bx, by, bw, bh, num, den;
		bit found;
		ans.r = '0;
		ans.st = ST_CLEARED;
		if (op == OP_NONE) return 0;
		if (op == OP_CLEAR) begin
			obst_cnt = 0;
			return 1;
		end
		if (obst_cnt >= MAX_OBST) begin
			ans.st = ST_FULL;
			return 1;
		end
		if (op == OP_ADD) begin
			obst[obst_cnt] = r;
			obst_cnt++;
			ans.r = r;
			ans.st = ST_ADDED;
			return 1;
		end
		a = area;
		shape_n = 0;
		if (a == 0) begin
			shape_w[0] = 1; shape_h[0] = 1; shape_n = 1;
		end else begin
			for (int k = 0; k < 3; k++) begin
				num = (k == 1) ? 2 * a : a;
				den = (k == 2) ? 2 : 1;
				rt = least_root(num, den);
				if (rt < 1) rt = 1;
				h = (a + rt - 1) / rt;
				shape_add(rt, h, a);
				shape_add(h, rt, a);
			end
		end
		found = 0;
		bx = 0; by = 0; bw = 0; bh = 0;
		for (int s = 0; s < shape_n; s++) begin
			w = shape_w[s];
			h = shape_h[s];
			if (w > chip_w || h > chip_h) continue;
			for (int i = 0; i < 2 + 2 * obst_cnt; i++) begin
				if (i == 0)
					x = 0;
				else if (i == 1)
					x = (chip_w - w > 0) ? chip_w - w : 0;
				else if (((i - 2) & 1) == 0)
					x = longint'(obst[(i - 2) / 2].x) + longint'(obst[(i - 2) / 2].w);
				else
					x = longint'(obst[(i - 2) / 2].x) - w;
				if (x < 0 || x + w > chip_w) continue;
				y = drop_y(x, w, h);
				if (y < 0) continue;
				if (!found || y < by || (y == by && x < bx)) begin
					found = 1;
					bx = x; by = y; bw = w; bh = h;
				end
			end
		end
		if (!found) begin
			ans.st = ST_NOFIT;
			return 1;
		end
		ans.r.x = bx[15:0];
		ans.r.y = by[15:0];
		ans.r.w = bw[15:0];
		ans.r.h = bh[15:0];
		ans.st = ST_PLACED;
		obst[obst_cnt] = ans.r;
		obst_cnt++;
		return 1;
	endfunction

	function automatic row_t mk_row(logic [1:0] op, int x, int y, int w, int h,
			longint a, bit typed = 0, int ex = 0, int ey = 0, int ew = 0, int eh = 0,
			status_t st = ST_CLEARED);
		row_t rw;
		rw.op = op;
		rw.r = '{x: x[15:0], y: y[15:0], w: w[15:0], h: h[15:0]};
		rw.a = a[31:0];
		rw.typed = typed;
		rw.ans.r = '{x: ex[15:0], y: ey[15:0], w: ew[15:0], h: eh[15:0]};
		rw.ans.st = st;
		return rw;
	endfunction

	// appends one row to the directed table
	function automatic void add_row(row_t rw);
		rows.insert(rows.size(), rw);
	endfunction

	// mostly short gaps, some medium, a few long
	function automatic int pick_gap(bit calm);
		int p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 70) return $urandom_range(0, 2);
		if (p < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// one request beat; the mirror runs at the accepting edge
	task automatic send_beat(row_t rw);
		int g;
		answer_t ans;
		g = pick_gap(calm_src);
		@(negedge clk);
		if (g > 0) begin
			req.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		req.operation = rw.op;
		req.rect_x = rw.r.x;
		req.rect_y = rw.r.y;
		req.rect_w = rw.r.w;
		req.rect_h = rw.r.h;
		req.area = rw.a;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		if (placer_answer(rw.op, rw.r, rw.a, ans)) begin
			if (rw.typed) ans = rw.ans;
			answer_q.insert(answer_q.size(), ans);
		end
	endtask

	task automatic end_burst();
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	// wait for every response, then a pause so a swallowed request has drained
	task automatic settle();
		end_burst();
		while (answer_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
		if (idx == REG_WIDTH)
			chip_w = val;
		else
			chip_h = val;
	endtask

	// random obstacle, mostly inside the chip, sometimes anywhere
	function automatic rect_t rand_rect();
		rect_t r;
		if ($urandom_range(0, 9) == 0) begin
			r = {$urandom, $urandom};
		end else begin
			r.x = $urandom_range(0, int'(chip_w));
			r.y = $urandom_range(0, int'(chip_h));
			r.w = $urandom_range(0, int'(chip_w / 4 + 1));
			r.h = $urandom_range(0, int'(chip_h / 4 + 1));
		end
		return r;
	endfunction

	// well-formed mix: table kept short so each placement stays cheap
	task automatic run_random(int count);
		row_t rw;
		int p, done;
		longint amax;
		done = 0;
		while (done < count) begin
			p = $urandom_range(0, 99);
			rw = mk_row(OP_CLEAR, 0, 0, 0, 0, 0);
			rw.r = rand_rect();
			amax = chip_w * chip_h / 16 + 2;
			if ($urandom_range(0, 9) == 0)
				rw.a = $urandom;
			else
				rw.a = $urandom_range(0, int'(amax));
			if (obst_cnt >= 6 || p < 8)
				rw.op = OP_CLEAR;
			else if (p < 40)
				rw.op = OP_ADD;
			else if (p < 93)
				rw.op = OP_PLACE;
			else
				rw.op = OP_NONE;
			if (rw.op != OP_NONE) done++;
			send_beat(rw);
		end
	endtask

	task automatic run_phase(int w, int h, int count);
		settle();
		write_reg(REG_WIDTH, w[15:0]);
		write_reg(REG_HEIGHT, h[15:0]);
		calm_src = $urandom_range(0, 2) == 0;
		calm_snk = $urandom_range(0, 2) == 0;
		send_beat(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_CLEARED));
		run_random(count);
	endtask

	// response side: random stalls, one long hold once the table is filling
	always @(negedge clk) begin
		if (!hold_done && beats_seen >= 30) begin
			hold_done <= 1'b1;
			hold_cnt <= 400;
			rsp.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp.ready <= 1'b0;
		end else if (calm_snk) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= (pick_gap(1'b0) == 0);
		end
	end

	// response checker
	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && rsp.valid && rsp.ready) begin
			beats_seen <= beats_seen + 1;
			case (rsp.status)
				ST_ADDED:   n_added++;
				ST_PLACED:  n_placed++;
				ST_NOFIT:   n_nofit++;
				ST_FULL:    n_full++;
				ST_CLEARED: n_cleared++;
				default: ;
			endcase
			if (answer_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response beat: status %0d", rsp.status);
			end else begin
				exp_a = answer_q.pop_front();
				if (rsp.placed_x !== exp_a.r.x || rsp.placed_y !== exp_a.r.y ||
						rsp.placed_w !== exp_a.r.w || rsp.placed_h !== exp_a.r.h ||
						rsp.status !== exp_a.st) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %0d,%0d,%0d,%0d st %0d, got %0d,%0d,%0d,%0d st %0d",
							exp_a.r.x, exp_a.r.y, exp_a.r.w, exp_a.r.h, exp_a.st,
							rsp.placed_x, rsp.placed_y, rsp.placed_w, rsp.placed_h,
							rsp.status);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bottom_left_rect_placer test failed");
			$finish;
		end
	end

	initial begin
		row_t rw;
		req.valid = 1'b0;
		req.operation = OP_NONE;
		req.rect_x = '0;
		req.rect_y = '0;
		req.rect_w = '0;
		req.rect_h = '0;
		req.area = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_WIDTH;
		cfg.data = '0;
		obst_cnt = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows on the reset chip, 1024 x 1024
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1, ST_PLACED));
		add_row(mk_row(OP_ADD, 0, 0, 65535, 65535, 0, 1, 0, 0, 65535, 65535, ST_ADDED));
		// zero-size obstacle: echoed, never blocks
		add_row(mk_row(OP_ADD, 5, 5, 0, 0, 0, 1, 5, 5, 0, 0, ST_ADDED));
		// everything is covered, nothing fits
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, ST_NOFIT));
		// unused operation: swallowed
		add_row(mk_row(OP_NONE, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF));
		add_row(mk_row(OP_CLEAR, 65535, 0, 65535, 0, 0, 1, 0, 0, 0, 0, ST_CLEARED));
		// largest area: every shape wider than the chip
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, ST_NOFIT));
		add_row(mk_row(OP_ADD, 65535, 65535, 65535, 65535, 0, 1,
			65535, 65535, 65535, 65535, ST_ADDED));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 100));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 5000));
		add_row(mk_row(OP_ADD, 10, 0, 20, 30, 0));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 50));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 2));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 3));
		add_row(mk_row(OP_ADD, 600, 0, 100, 900, 0));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 250000));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 1000000));
		add_row(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_CLEARED));
		add_row(mk_row(OP_PLACE, 0, 0, 0, 0, 1000));
		foreach (rows[i]) send_beat(rows[i]);

		// fill the table with adds under back-pressure, then hit the full case
		calm_src = 1'b1;
		send_beat(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_CLEARED));
		for (int i = 0; i < MAX_OBST; i++) begin
			rw = mk_row(OP_ADD, 0, 0, 0, 0, 0);
			rw.r = rand_rect();
			send_beat(rw);
		end
		send_beat(mk_row(OP_ADD, 1, 2, 3, 4, 0, 1, 0, 0, 0, 0, ST_FULL));
		send_beat(mk_row(OP_PLACE, 0, 0, 0, 0, 7, 1, 0, 0, 0, 0, ST_FULL));
		send_beat(mk_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_CLEARED));

		// chip size settings, extremes included; zero width blocks every shape
		run_phase(0, 1024, 4);
		run_phase(1, 1, 8);
		run_phase(65535, 65535, 12);
		run_phase(200, 100, 12);
		run_phase(1024, 1024, 12);

		settle();
		repeat (50) @(posedge clk);
		$display("covered: %0d added, %0d placed, %0d no-fit, %0d full, %0d cleared beats",
			n_added, n_placed, n_nofit, n_full, n_cleared);
		$display("chip sizes from 0 and 1 up to 65535, %0d mismatches in %0d cycles",
			errors, cycles);
		if (errors == 0)
			$display("bottom_left_rect_placer test passed");
		else
			$display("bottom_left_rect_placer test failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/blrp_pkg.sv
sv/blrp_ifs.sv
sv/blrp_cell.sv
sv/blrp_sqdiv.sv
sv/bottom_left_rect_placer.sv
tb/tb_bottom_left_rect_placer.sv
